FILE: src/brsc_pkg.sv
// Shared types and constants for the bitmap range set/clear block.
package brsc_pkg;

    localparam int OFFSET_W  = 12;
    localparam int COUNT_W   = 13;
    localparam int SUM_W     = COUNT_W + 1;
    localparam int BYTE_BITS = 8;
    localparam int BIT_SEL_W = 3;

    localparam logic [BYTE_BITS-1:0] BYTE_ONES = 8'hFF;
    localparam logic [BIT_SEL_W-1:0] TOP_BIT   = 3'd7;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] bit_offset;
        logic [COUNT_W-1:0]  bit_count;
    } brsc_req_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] overlap_bits;
        logic                 range_error;
    } brsc_rsp_t;

endpackage

FILE: src/brsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module brsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/bitmap_range_set_clear_core.sv
// Top level of the bitmap range set/clear block: sequencer around the bitmap RAM.
//
// A request is one beat on req, taken at a rising edge where start is high and busy
// is low. It sets (op = 0) or clears (op = 1) bit_count bits from bit_offset on.
// Exactly one result beat follows on rsp, marked by a one-cycle pulse on done; the
// receiver must take it in that cycle, as it cannot stall the block.
// The bitmap lives in a byte-wide RAM of (MAP_BITS + 7) / 8 entries. Each touched
// byte is read, masked and written back; the read of the next byte overlaps the
// write of the current one, so the RAM ports set the pace at one byte per cycle.
// A request holds busy until the last byte it touches is written back, and its result
// appears as busy falls; no new request is taken while a run is in progress.
// A request that runs past the end of the map, or has a zero count, is answered in
// the next cycle without touching the RAM. After reset the block walks the RAM once,
// writing zero to every byte, and busy stays high throughout that pass.
module bitmap_range_set_clear_core #(
    parameter int MAP_BITS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  brsc_pkg::brsc_req_t req,
    output logic                busy,
    output logic                done,
    output brsc_pkg::brsc_rsp_t rsp
);

    import brsc_pkg::*;

    localparam int MAP_BYTES = (MAP_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    brsc_rsp_t              rsp_reg, rsp_next;
    logic                   issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]      first_reg, first_next;
    logic [ADDR_W-1:0]      last_reg, last_next;
    logic [BIT_SEL_W-1:0]   first_bit_reg, first_bit_next;
    logic [BIT_SEL_W-1:0]   last_bit_reg, last_bit_next;
    logic                   op_reg, op_next;
    logic [BYTE_BITS-1:0]   found_reg, found_next;

    logic [SUM_W-1:0]       run_end;
    logic [SUM_W-1:0]       end_bit;
    logic                   req_err;
    logic                   req_empty;

    logic [BIT_SEL_W-1:0]   lo_bit;
    logic [BIT_SEL_W-1:0]   hi_bit;
    logic [BYTE_BITS-1:0]   run_mask;
    logic [BYTE_BITS-1:0]   hit_bits;
    logic [BYTE_BITS-1:0]   new_byte;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [BYTE_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [BYTE_BITS-1:0]   ram_rdata;

    brsc_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign run_end   = {2'b00, req.bit_offset} + {1'b0, req.bit_count};
    assign end_bit   = run_end - SUM_W'(1);
    assign req_err   = 32'(run_end) > 32'(MAP_BITS);
    assign req_empty = (req.bit_count == '0);

    assign lo_bit   = (pend_addr_reg == first_reg) ? first_bit_reg : '0;
    assign hi_bit   = (pend_addr_reg == last_reg) ? last_bit_reg : TOP_BIT;
    assign run_mask = (BYTE_ONES << lo_bit) & (BYTE_ONES >> (TOP_BIT - hi_bit));

    always_comb
    begin
        if (op_reg == OP_SET)
        begin
            hit_bits = ram_rdata & run_mask;
            new_byte = ram_rdata | run_mask;
        end
        else
        begin
            hit_bits = ~ram_rdata & run_mask;
            new_byte = ram_rdata & ~run_mask;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        clr_addr_next  = clr_addr_reg;
        rd_addr_next   = rd_addr_reg;
        pend_addr_next = pend_addr_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        first_bit_next = first_bit_reg;
        last_bit_next  = last_bit_reg;
        op_next        = op_reg;
        found_next     = found_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = new_byte;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_err || req_empty)
                    begin
                        done_next             = 1'b1;
                        rsp_next.overlap_bits = '0;
                        rsp_next.range_error  = req_err;
                    end
                    else
                    begin
                        state_next     = ST_RUN;
                        issue_next     = 1'b1;
                        pend_next      = 1'b0;
                        first_next     = ADDR_W'(req.bit_offset[OFFSET_W-1:BIT_SEL_W]);
                        last_next      = ADDR_W'(end_bit[SUM_W-1:BIT_SEL_W]);
                        rd_addr_next   = ADDR_W'(req.bit_offset[OFFSET_W-1:BIT_SEL_W]);
                        first_bit_next = req.bit_offset[BIT_SEL_W-1:0];
                        last_bit_next  = end_bit[BIT_SEL_W-1:0];
                        op_next        = req.op;
                        found_next     = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (issue_reg)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    if (rd_addr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we     = 1'b1;
                    found_next = found_reg | hit_bits;
                    if (!issue_reg)
                    begin
                        state_next            = ST_IDLE;
                        done_next             = 1'b1;
                        rsp_next.overlap_bits = found_reg | hit_bits;
                        rsp_next.range_error  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        first_bit_reg <= first_bit_next;
        last_bit_reg  <= last_bit_next;
        op_reg        <= op_next;
        found_reg     <= found_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A write-back never targets the byte being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap RAM read and write hit the same byte");

    // An out-of-range request is answered in the next cycle with an error and no bits.
    a_err_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_err) |=> (done && rsp.range_error && rsp.overlap_bits == '0))
        else $error("out-of-range request not answered with an error");

    // The final write-back of a run produces the result and frees the block.
    a_run_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && pend_reg && !issue_reg) |=> (done && !busy))
        else $error("run did not finish after its last write-back");

    // No result leaves the block while the reset clearing pass is running.
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result beat during the clearing pass");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the bitmap range set/clear core: directed table, then random runs.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brsc_pkg::*;

    localparam int MAP_BITS     = 4096;
    localparam int MAP_BYTES    = (MAP_BITS + 7) / 8;
    localparam int RANDOM_RUNS  = 1130;
    localparam int NUM_DIRECTED = 23;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        brsc_req_t run;
        logic      known;
        brsc_rsp_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{'{OP_SET,   12'd0,    13'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd4095, 13'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd4095, 13'd2},    1'b1, '{8'h00, 1'b1}},
        '{'{OP_CLEAR, 12'd0,    13'd8191}, 1'b1, '{8'h00, 1'b1}},
        '{'{OP_SET,   12'd0,    13'd4097}, 1'b1, '{8'h00, 1'b1}},
        '{'{OP_SET,   12'd4095, 13'd8191}, 1'b1, '{8'h00, 1'b1}},
        '{'{OP_SET,   12'd0,    13'd8},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd0,    13'd8},    1'b1, '{8'hFF, 1'b0}},
        '{'{OP_CLEAR, 12'd0,    13'd8},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd0,    13'd8},    1'b1, '{8'hFF, 1'b0}},
        '{'{OP_SET,   12'd4095, 13'd1},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd4095, 13'd1},    1'b1, '{8'h80, 1'b0}},
        '{'{OP_CLEAR, 12'd4095, 13'd1},    1'b1, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd3,    13'd10},   1'b0, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd0,    13'd16},   1'b0, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd5,    13'd3},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd7,    13'd2},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd0,    13'd4096}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd0,    13'd4096}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd0,    13'd4096}, 1'b1, '{8'hFF, 1'b0}},
        '{'{OP_SET,   12'd4088, 13'd8},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_CLEAR, 12'd4090, 13'd6},    1'b0, '{8'h00, 1'b0}},
        '{'{OP_SET,   12'd1,    13'd4095}, 1'b0, '{8'h00, 1'b0}}
    };

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    brsc_req_t req   = '0;
    logic      busy;
    logic      done;
    brsc_rsp_t rsp;

    logic [BYTE_BITS-1:0] shadow_map [MAP_BYTES];
    brsc_rsp_t            pending_rsp [$];

    int mismatches  = 0;
    int checked     = 0;
    int sets_sent   = 0;
    int clears_sent = 0;
    int past_end    = 0;
    int empty_runs  = 0;
    int widest_run  = 0;

    bitmap_range_set_clear_core #(
        .MAP_BITS(MAP_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    always #4 clk = ~clk;

    function automatic brsc_rsp_t apply_run(input brsc_req_t r);
        brsc_rsp_t            res;
        int unsigned          pos;
        int unsigned          stop;
        logic [BYTE_BITS-1:0] m;
        res  = '0;
        stop = int'(r.bit_offset) + int'(r.bit_count);
        if (stop > MAP_BITS)
        begin
            res.range_error = 1'b1;
            return res;
        end
        for (pos = 32'(r.bit_offset); pos < stop; pos++)
        begin
            m = BYTE_BITS'(1) << (pos % BYTE_BITS);
            if (r.op == OP_SET)
            begin
                if ((shadow_map[pos / BYTE_BITS] & m) != '0)
                    res.overlap_bits |= m;
                shadow_map[pos / BYTE_BITS] |= m;
            end
            else
            begin
                if ((shadow_map[pos / BYTE_BITS] & m) == '0)
                    res.overlap_bits |= m;
                shadow_map[pos / BYTE_BITS] &= ~m;
            end
        end
        return res;
    endfunction

    function automatic brsc_req_t random_run();
        brsc_req_t   r;
        int unsigned kind;
        int unsigned cnt;
        kind = $urandom_range(0, 99);
        r.op = ($urandom_range(0, 1) == 0) ? OP_SET : OP_CLEAR;
        if (kind < 8)
        begin
            r.bit_offset = OFFSET_W'($urandom);
            r.bit_count  = COUNT_W'($urandom);
            if (int'(r.bit_offset) + int'(r.bit_count) <= MAP_BITS)
                r.bit_count = COUNT_W'(MAP_BITS - int'(r.bit_offset) + 1
                                       + $urandom_range(0, 100));
        end
        else if (kind < 12)
        begin
            r.bit_offset = OFFSET_W'($urandom);
            r.bit_count  = '0;
        end
        else
        begin
            if (kind < 15)
                cnt = $urandom_range(1, MAP_BITS);
            else if (kind < 30)
                cnt = $urandom_range(1, 256);
            else
                cnt = $urandom_range(1, 24);
            r.bit_count = COUNT_W'(cnt);
            if (kind >= 30 && $urandom_range(0, 1) == 0)
                r.bit_offset = OFFSET_W'($urandom_range(0, 127));
            else
                r.bit_offset = OFFSET_W'($urandom_range(0, MAP_BITS - cnt));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic send_run(input brsc_req_t r, input logic known, input brsc_rsp_t want);
        brsc_rsp_t predicted;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_run(r);
        pending_rsp.push_back(known ? want : predicted);
        if (r.op == OP_SET)
            sets_sent++;
        else
            clears_sent++;
        if (predicted.range_error)
            past_end++;
        else if (r.bit_count == '0)
            empty_runs++;
        else if (int'(r.bit_count) > widest_run)
            widest_run = int'(r.bit_count);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        brsc_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected result beat", 0, int'(rsp));
            end
            else
            begin
                want = pending_rsp.pop_front();
                checked++;
                if (rsp.overlap_bits !== want.overlap_bits)
                    report_mismatch("overlap_bits", int'(want.overlap_bits),
                                    int'(rsp.overlap_bits));
                if (rsp.range_error !== want.range_error)
                    report_mismatch("range_error", int'(want.range_error),
                                    int'(rsp.range_error));
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int burst_left;
        int k;
        for (k = 0; k < MAP_BYTES; k++)
            shadow_map[k] = '0;
        burst_left = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            send_run(DIRECTED[k].run, DIRECTED[k].known, DIRECTED[k].want);
            if (k % 5 == 4)
                idle_for($urandom_range(1, 6));
        end
        drain_results();

        for (k = 0; k < RANDOM_RUNS; k++)
        begin
            if (k % 250 == 125)
            begin
                drain_results();
            end
            else if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 12));
            end
            burst_left--;
            send_run(random_run(), 1'b0, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Checked %0d result beats: %0d set runs and %0d clear runs.",
                 checked, sets_sent, clears_sent);
        $display("Runs past the end: %0d, empty runs: %0d, widest run: %0d bits.",
                 past_end, empty_runs, widest_run);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
src/brsc_pkg.sv
src/brsc_ram.sv
src/bitmap_range_set_clear_core.sv
tb/tb.sv
